>>> hw/rtl/idle_brightness_ramp_unit_macros.svh
// assertion macros for the idle brightness ramp unit
// no dependencies; included by the top level
`ifndef IDLE_BRIGHTNESS_RAMP_UNIT_MACROS_SVH
`define IDLE_BRIGHTNESS_RAMP_UNIT_MACROS_SVH

// consequent must hold whenever the antecedent holds
`define IBR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ibr check failed");

// expression must hold at every edge out of reset
`define IBR_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("ibr check failed");

`endif

>>> hw/rtl/ibr_pkg.sv
// types and constants for the idle brightness ramp unit
// no dependencies
package ibr_pkg;

  typedef logic [6:0]  pct_t;
  typedef logic [15:0] tick_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_DOWN = 2'd1,
    DIR_UP   = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    KIND_ACTIVE = 2'd0,
    KIND_IDLE   = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NOTICE = 2'd3
  } kind_t;

  localparam pct_t  FULL_PERCENT      = 7'd100;
  localparam pct_t  FLOOR_RESET       = 7'd10;
  localparam tick_t INTERVAL_RESET    = 16'd50;
  localparam logic  REG_FLOOR         = 1'b0;
  localparam logic  REG_INTERVAL      = 1'b1;
  localparam int    CFG_ADDR_W        = 3;

  function automatic pct_t sat_pct(input pct_t v);
    sat_pct = (v > FULL_PERCENT) ? FULL_PERCENT : v;
  endfunction

endpackage

>>> hw/rtl/ibr_if.sv
// item channels of the idle brightness ramp unit
// depends on ibr_pkg
interface ibr_in_if import ibr_pkg::*;;
  logic  valid;
  logic  ready;
  kind_t kind;
  pct_t  level_percent;

  modport source (output valid, kind, level_percent, input ready);
  modport sink   (input valid, kind, level_percent, output ready);
endinterface

interface ibr_out_if import ibr_pkg::*;;
  logic       valid;
  logic       ready;
  logic       brightness_write;
  pct_t       brightness_percent;
  logic [1:0] ramp_state;
  logic       step_pending;

  modport source (output valid, brightness_write, brightness_percent, ramp_state,
                  step_pending, input ready);
  modport sink   (input valid, brightness_write, brightness_percent, ramp_state,
                  step_pending, output ready);
endinterface

>>> hw/rtl/idle_brightness_ramp_unit.sv
// idle brightness ramp unit: top level with input register, step logic and result register
// depends on ibr_pkg, ibr_if and idle_brightness_ramp_unit_macros.svh
//
// Takes one event item per cycle (active, idle, tick, user notice) while the result
// register is free or being taken, and returns one result item per event with the
// brightness after it. Each item passes through the input register and then the result
// register; the whole state update happens in the single step stage between them, and
// a full result register that is not taken stalls both stages. Ramp steps move the level
// by ceil(diff / RAMP_STEPS), looked up in a constant table over the 0..127 range.
// Registers: floor_percent at byte 0 (saturated to 100 on write), step_interval_ticks
// at byte 4 (zero acts as one tick).
`include "idle_brightness_ramp_unit_macros.svh"

module idle_brightness_ramp_unit import ibr_pkg::*; #(
  parameter int unsigned RAMP_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ibr_in_if.sink                in_chan,
  ibr_out_if.source             out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // configuration
  pct_t  floor_r;
  tick_t interval_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_INTERVAL) ? {16'd0, interval_r} : {25'd0, floor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r    <= FLOOR_RESET;
      interval_r <= INTERVAL_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_INTERVAL) begin
        interval_r <= pwdata[15:0];
      end else begin
        floor_r <= sat_pct(pwdata[6:0]);
      end
    end
  end

  // step size table
  pct_t step_lut [0:127];
  for (genvar gi = 0; gi < 128; gi++) begin : g_lut
    assign step_lut[gi] = 7'((gi + RAMP_STEPS - 1) / RAMP_STEPS);
  end

  // pipeline control
  logic  in_vld_r;
  kind_t in_kind_r;
  pct_t  in_lvl_r;
  logic  out_vld_r;
  logic  advance;
  logic  fire;

  assign advance       = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !in_vld_r || advance;
  assign fire          = in_vld_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_kind_r <= in_chan.kind;
      in_lvl_r  <= sat_pct(in_chan.level_percent);
    end
  end

  // ramp state
  pct_t  wake_r, wake_nxt;
  pct_t  cur_r, cur_nxt;
  dir_t  dir_r, dir_nxt;
  logic  pend_r, pend_nxt;
  tick_t cnt_r, cnt_nxt;
  logic  wrote_nxt;

  pct_t  target;
  pct_t  diff;
  pct_t  step;
  pct_t  stepped;
  tick_t reload;

  always_comb begin
    target  = (dir_r == DIR_DOWN) ? floor_r : wake_r;
    diff    = (target > cur_r) ? target - cur_r : cur_r - target;
    step    = (step_lut[diff] > diff) ? diff : step_lut[diff];
    if (step == 7'd0) begin
      step = 7'd1;
    end
    stepped = (target > cur_r) ? cur_r + step : cur_r - step;
    reload  = (interval_r == 16'd0) ? 16'd1 : interval_r;
  end

  always_comb begin
    wake_nxt  = wake_r;
    cur_nxt   = cur_r;
    dir_nxt   = dir_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    wrote_nxt = 1'b0;
    case (in_kind_r)
      KIND_ACTIVE: begin
        if (!(dir_r == DIR_NONE && cur_r == wake_r)) begin
          dir_nxt = DIR_UP;
          if (!pend_r) begin
            pend_nxt = 1'b1;
            cnt_nxt  = 16'd1;
          end
        end
      end
      KIND_IDLE: begin
        if (wake_r == 7'd0) begin
          wake_nxt = (in_lvl_r > floor_r) ? in_lvl_r : FULL_PERCENT;
          cur_nxt  = (in_lvl_r != 7'd0) ? in_lvl_r : wake_nxt;
        end else if (dir_r == DIR_NONE && in_lvl_r > floor_r) begin
          wake_nxt = in_lvl_r;
          cur_nxt  = in_lvl_r;
        end
        dir_nxt = DIR_DOWN;
        if (!pend_r) begin
          pend_nxt = 1'b1;
          cnt_nxt  = 16'd1;
        end
      end
      KIND_TICK: begin
        if (pend_r) begin
          if (cnt_r <= 16'd1) begin
            pend_nxt = 1'b0;
            cnt_nxt  = 16'd0;
            if (cur_r == target) begin
              dir_nxt = DIR_NONE;
            end else begin
              wrote_nxt = 1'b1;
              cur_nxt   = stepped;
              if (stepped != target) begin
                pend_nxt = 1'b1;
                cnt_nxt  = reload;
              end else begin
                dir_nxt = DIR_NONE;
              end
            end
          end else begin
            cnt_nxt = cnt_r - 16'd1;
          end
        end
      end
      default: begin
        if (dir_r == DIR_NONE && in_lvl_r > floor_r) begin
          wake_nxt = in_lvl_r;
          cur_nxt  = in_lvl_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wake_r <= '0;
      cur_r  <= '0;
      dir_r  <= DIR_NONE;
      pend_r <= 1'b0;
      cnt_r  <= '0;
    end else if (fire) begin
      wake_r <= wake_nxt;
      cur_r  <= cur_nxt;
      dir_r  <= dir_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // result register
  logic       res_wr_r;
  pct_t       res_pct_r;
  logic [1:0] res_dir_r;
  logic       res_pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_wr_r   <= wrote_nxt;
      res_pct_r  <= cur_nxt;
      res_dir_r  <= dir_nxt;
      res_pend_r <= pend_nxt;
    end
  end

  assign out_chan.valid              = out_vld_r;
  assign out_chan.brightness_write   = res_wr_r;
  assign out_chan.brightness_percent = res_pct_r;
  assign out_chan.ramp_state         = res_dir_r;
  assign out_chan.step_pending       = res_pend_r;

  // checks
  `IBR_ASSERT_IMPLY(a_pend_has_dir, clk, rst_n, pend_r, dir_r != DIR_NONE)
  `IBR_ASSERT_IMPLY(a_pend_has_count, clk, rst_n, pend_r, cnt_r != 16'd0)
  `IBR_ASSERT_ALWAYS(a_level_in_range, clk, rst_n, cur_r <= FULL_PERCENT && wake_r <= FULL_PERCENT)

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// testbench for idle_brightness_ramp_unit: directed and random event items with a
// built-in predictor of the ramp, apb register setup and random flow control
// depends on ibr_pkg, ibr_if and the rtl of the unit
module tb_top;
  import ibr_pkg::*;

  localparam int RAMP_STEPS   = 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int PHASE_ITEMS  = 135;
  localparam int DRAIN_CYCLES = 10;
  localparam int PRINT_LIMIT  = 30;

  typedef struct packed {
    logic       wrote;
    pct_t       pct;
    logic [1:0] dir;
    logic       pend;
  } lamp_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  ibr_in_if  ev_chan ();
  ibr_out_if res_chan ();

  idle_brightness_ramp_unit #(.RAMP_STEPS(RAMP_STEPS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (ev_chan),
    .out_chan (res_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // predictor state
  pct_t  floor_level    = FLOOR_RESET;
  tick_t interval_ticks = INTERVAL_RESET;
  pct_t  wake_pct       = '0;
  pct_t  level_pct      = '0;
  dir_t  ramp_dir       = DIR_NONE;
  logic  step_due       = 1'b0;
  tick_t tick_count     = '0;

  lamp_result_t result_q[$];

  int mismatches      = 0;
  int items_accepted  = 0;
  int results_checked = 0;
  int writes_checked  = 0;
  int settings_used   = 0;
  int quiet_cycles    = 0;
  int idle_pct        = 0;
  int stall_pct       = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic take_step();
    pct_t goal;
    int   diff;
    int   stride;
    goal = (ramp_dir == DIR_DOWN) ? floor_level : wake_pct;
    step_due = 1'b0;
    tick_count = '0;
    if (level_pct == goal) begin
      ramp_dir = DIR_NONE;
      return 1'b0;
    end
    diff = (goal > level_pct) ? int'(goal) - int'(level_pct) : int'(level_pct) - int'(goal);
    stride = (diff + RAMP_STEPS - 1) / RAMP_STEPS;
    if (stride < 1) stride = 1;
    if (stride > diff) stride = diff;
    if (goal > level_pct) level_pct = level_pct + pct_t'(stride);
    else level_pct = level_pct - pct_t'(stride);
    if (level_pct != goal) begin
      step_due = 1'b1;
      tick_count = (interval_ticks == '0) ? tick_t'(1) : interval_ticks;
    end else begin
      ramp_dir = DIR_NONE;
    end
    return 1'b1;
  endfunction

  function automatic void arm_step();
    if (!step_due) begin
      step_due = 1'b1;
      tick_count = tick_t'(1);
    end
  endfunction

  function automatic lamp_result_t apply_event(kind_t kind, pct_t raw);
    pct_t         lvl;
    logic         wrote;
    lamp_result_t r;
    lvl = (raw > FULL_PERCENT) ? FULL_PERCENT : raw;
    wrote = 1'b0;
    case (kind)
      KIND_ACTIVE: begin
        if (!(ramp_dir == DIR_NONE && level_pct == wake_pct)) begin
          ramp_dir = DIR_UP;
          arm_step();
        end
      end
      KIND_IDLE: begin
        // first idle anchors the wake level, later ones only when settled
        if (wake_pct == '0) begin
          wake_pct = (lvl > floor_level) ? lvl : FULL_PERCENT;
          level_pct = (lvl != '0) ? lvl : wake_pct;
        end else if (ramp_dir == DIR_NONE && lvl > floor_level) begin
          wake_pct = lvl;
          level_pct = lvl;
        end
        ramp_dir = DIR_DOWN;
        arm_step();
      end
      KIND_TICK: begin
        if (step_due) begin
          if (tick_count <= tick_t'(1)) wrote = take_step();
          else tick_count = tick_count - tick_t'(1);
        end
      end
      default: begin
        if (ramp_dir == DIR_NONE && lvl > floor_level) begin
          wake_pct = lvl;
          level_pct = lvl;
        end
      end
    endcase
    r.wrote = wrote;
    r.pct = level_pct;
    r.dir = ramp_dir;
    r.pend = step_due;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && ev_chan.valid && ev_chan.ready) begin
      result_q.push_back(apply_event(ev_chan.kind, ev_chan.level_percent));
      items_accepted++;
    end
  end

  always @(posedge clk) begin : result_check
    lamp_result_t want;
    if (rst_n && res_chan.valid && res_chan.ready) begin
      if (result_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", res_chan.brightness_percent, 0);
      end else begin
        want = result_q.pop_front();
        results_checked++;
        if (want.wrote) writes_checked++;
        if (res_chan.brightness_write !== want.wrote)
          report_mismatch("brightness_write", res_chan.brightness_write, want.wrote);
        if (res_chan.brightness_percent !== want.pct)
          report_mismatch("brightness_percent", res_chan.brightness_percent, want.pct);
        if (res_chan.ramp_state !== want.dir)
          report_mismatch("ramp_state", res_chan.ramp_state, want.dir);
        if (res_chan.step_pending !== want.pend)
          report_mismatch("step_pending", res_chan.step_pending, want.pend);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (ev_chan.valid && ev_chan.ready) || (res_chan.valid && res_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    res_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_chan.ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic cfg_write(logic reg_sel, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({reg_sel, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_FLOOR)
      floor_level = (value[6:0] > FULL_PERCENT) ? FULL_PERCENT : value[6:0];
    else
      interval_ticks = value[15:0];
  endtask

  task automatic cfg_read_check(logic reg_sel);
    logic [31:0] want;
    want = (reg_sel == REG_FLOOR) ? {25'd0, floor_level} : {16'd0, interval_ticks};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CFG_ADDR_W'({reg_sel, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report_mismatch(reg_sel == REG_FLOOR ? "floor readback" : "interval readback",
                      prdata, want);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_settings(logic [31:0] floor_value, logic [31:0] interval_value);
    cfg_write(REG_FLOOR, floor_value);
    cfg_write(REG_INTERVAL, interval_value);
    cfg_read_check(REG_FLOOR);
    cfg_read_check(REG_INTERVAL);
    settings_used++;
  endtask

  task automatic send_item(kind_t kind, pct_t level);
    if ($urandom_range(99) < idle_pct) begin
      ev_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    ev_chan.valid <= 1'b1;
    ev_chan.kind <= kind;
    ev_chan.level_percent <= level;
    do @(posedge clk); while (!ev_chan.ready);
  endtask

  // sender holds off until the last outstanding result has been checked
  task automatic drain_results();
    ev_chan.valid <= 1'b0;
    @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
  endtask

  function automatic pct_t pick_level();
    if ($urandom_range(4) == 0) return pct_t'($urandom_range(127, 101));
    return pct_t'($urandom_range(100));
  endfunction

  task automatic test_register_reset();
    cfg_read_check(REG_FLOOR);
    cfg_read_check(REG_INTERVAL);
  endtask

  task automatic test_directed_events();
    kind_t kinds[25] = '{
      KIND_TICK, KIND_ACTIVE, KIND_NOTICE, KIND_IDLE, KIND_TICK,
      KIND_ACTIVE, KIND_TICK, KIND_TICK, KIND_TICK, KIND_TICK,
      KIND_TICK, KIND_NOTICE, KIND_NOTICE, KIND_IDLE, KIND_TICK,
      KIND_IDLE, KIND_TICK, KIND_ACTIVE, KIND_NOTICE, KIND_IDLE,
      KIND_TICK, KIND_IDLE, KIND_ACTIVE, KIND_TICK, KIND_TICK};
    pct_t levels[25] = '{
      7'd0, 7'd0, 7'd10, 7'd0, 7'd0,
      7'd0, 7'd127, 7'd0, 7'd0, 7'd0,
      7'd0, 7'd127, 7'd11, 7'd3, 7'd0,
      7'd5, 7'd0, 7'd0, 7'd50, 7'd127,
      7'd0, 7'd127, 7'd0, 7'd0, 7'd0};
    idle_pct = 0;
    stall_pct = 0;
    apply_settings(32'd10, 32'd1);
    foreach (kinds[i]) send_item(kinds[i], levels[i]);
    drain_results();
  endtask

  task automatic test_random_phase(int sender_idle, int receiver_stall,
                                   logic [31:0] floor_value, logic [31:0] interval_value);
    int    sent;
    int    run;
    int    r;
    kind_t k;
    drain_results();
    apply_settings(floor_value, interval_value);
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      r = $urandom_range(9);
      if (r == 0) begin
        send_item(kind_t'($urandom_range(3)), pct_t'($urandom_range(127)));
        sent++;
      end else begin
        // one event followed by a run of ticks that lets the ramp advance
        r = $urandom_range(99);
        k = (r < 45) ? KIND_IDLE : (r < 85) ? KIND_ACTIVE : KIND_NOTICE;
        send_item(k, pick_level());
        sent++;
        run = $urandom_range(40);
        repeat (run) begin
          if (sent < PHASE_ITEMS) begin
            send_item(KIND_TICK, pct_t'($urandom_range(127)));
            sent++;
          end
        end
      end
    end
    drain_results();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_wrap_up();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (result_q.size() != 0) report_mismatch("results never delivered", 0, result_q.size());
    $display("checked %0d results for %0d event items, %0d of them ramp writes",
             results_checked, items_accepted, writes_checked);
    $display("across %0d register settings with sender gaps and receiver stalls",
             settings_used);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  endtask

  initial begin
    ev_chan.valid <= 1'b0;
    ev_chan.kind <= KIND_TICK;
    ev_chan.level_percent <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst_n <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_reset();
    test_directed_events();
    test_random_phase(0, 0, 32'd0, 32'd1);
    test_random_phase(87, 0, 32'd100, 32'd0);
    test_random_phase(0, 87, 32'd127, 32'd2);
    test_random_phase(37, 37, $urandom_range(100), 32'd65535);
    test_random_phase(0, 0, $urandom_range(127), 32'd3);
    test_random_phase(87, 0, 32'd10, 32'd1);
    test_random_phase(0, 87, $urandom_range(100), $urandom_range(6, 1));
    test_random_phase(37, 37, 32'd50, 32'd1);
    test_wrap_up();
  end

endmodule
